// File: rtl/m4inv_pkg.sv
`default_nettype none
package m4inv_pkg;

  localparam int DataW = 32;
  localparam int ThrW = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd2;
  localparam int OpW = 33;
  localparam int ProdW = 66;
  localparam int MinorW = 65;
  localparam int CofW = 97;
  localparam int AccW = 131;
  localparam int DmagW = 130;
  localparam int NumW = CofW + 32;
  localparam int DenW = DmagW + 31;
  localparam int QuotW = 32;

  typedef enum logic [1:0] {
    ASEL_ENTRY = 2'd0,
    ASEL_MINOR = 2'd1,
    ASEL_COF   = 2'd2
  } asel_t;

  typedef struct packed {
    logic       vld;
    asel_t      asel;
    logic [1:0] piece;
    logic       neg;
    logic       clr;
    logic       to_minor;
    logic       store;
    logic [3:0] cof_idx;
    logic [3:0] addr_a;
    logic [3:0] addr_b;
  } mac_op_t;

  // i-th index of 0..3 with x left out
  function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] i);
    return (i < x) ? i : i + 2'd1;
  endfunction

endpackage
`default_nettype wire

// File: rtl/m4inv_if.sv
`default_nettype none
interface m4inv_entry_if;
  logic                                valid;
  logic                                ready;
  logic signed [m4inv_pkg::DataW-1:0]  matrix_entry;
  modport source(output valid, output matrix_entry, input ready);
  modport sink(input valid, input matrix_entry, output ready);
endinterface

interface m4inv_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [m4inv_pkg::DataW-1:0]  result_entry;
  logic signed [m4inv_pkg::DataW-1:0]  determinant;
  logic                                singular;
  logic                                last_entry;
  modport source(output valid, output result_entry, output determinant, output singular,
                 output last_entry, input ready);
  modport sink(input valid, input result_entry, input determinant, input singular,
               input last_entry, output ready);
endinterface
`default_nettype wire

// File: rtl/m4inv_mac.sv
`default_nettype none
module m4inv_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_en,
  input  wire logic [3:0]                        wr_addr,
  input  wire logic [m4inv_pkg::DataW-1:0]       wr_data,
  input  wire m4inv_pkg::mac_op_t                op,
  input  wire logic [3:0]                        cof_rd_idx,
  output logic [m4inv_pkg::CofW-1:0]             cof_rd_data,
  output logic [m4inv_pkg::AccW-1:0]             acc
);

  localparam int DW = m4inv_pkg::DataW;
  localparam int OW = m4inv_pkg::OpW;
  localparam int PW = m4inv_pkg::ProdW;
  localparam int MW = m4inv_pkg::MinorW;
  localparam int CW = m4inv_pkg::CofW;
  localparam int AW = m4inv_pkg::AccW;

  logic [DW-1:0]        mem_r [16];
  logic [DW-1:0]        rd_a_r;
  logic [DW-1:0]        rd_b_r;
  m4inv_pkg::mac_op_t   op1_r;
  m4inv_pkg::mac_op_t   op2_r;
  logic signed [PW-1:0] prod_r;
  logic signed [MW-1:0] minor_r;
  logic signed [AW-1:0] acc_r;
  logic [CW-1:0]        cof_r [16];

  logic [3:0]           cof_addr;
  logic [CW-1:0]        cof_sel;
  logic signed [OW-1:0] opa;
  logic signed [OW-1:0] opb;
  logic signed [AW-1:0] term_w;
  logic signed [AW-1:0] term_sh;
  logic signed [AW-1:0] term_n;
  logic signed [AW-1:0] acc_nxt;

  // matrix store, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[op.addr_a];
    rd_b_r <= mem_r[op.addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r <= '0;
      op2_r <= '0;
    end else begin
      op1_r <= op;
      op2_r <= op1_r;
    end
  end

  assign cof_addr = (op1_r.vld && op1_r.asel == m4inv_pkg::ASEL_COF) ? op1_r.cof_idx
                                                                    : cof_rd_idx;
  assign cof_sel = cof_r[cof_addr];
  assign cof_rd_data = cof_sel;

  // operand select for the shared multiplier
  always_comb begin
    opb = {rd_b_r[DW-1], rd_b_r};
    unique case (op1_r.asel)
      m4inv_pkg::ASEL_ENTRY: opa = {rd_a_r[DW-1], rd_a_r};
      m4inv_pkg::ASEL_MINOR: opa = (op1_r.piece == 2'd0) ? {1'b0, minor_r[31:0]}
                                                          : minor_r[MW-1:32];
      m4inv_pkg::ASEL_COF: begin
        case (op1_r.piece)
          2'd0:    opa = {1'b0, cof_sel[31:0]};
          2'd1:    opa = {1'b0, cof_sel[63:32]};
          default: opa = cof_sel[CW-1:64];
        endcase
      end
      default: opa = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  // accumulate stage
  always_comb begin
    term_w = AW'(prod_r);
    case (op2_r.piece)
      2'd0:    term_sh = term_w;
      2'd1:    term_sh = term_w <<< 32;
      default: term_sh = term_w <<< 64;
    endcase
    term_n = op2_r.neg ? -term_sh : term_sh;
    acc_nxt = (op2_r.clr ? '0 : acc_r) + term_n;
  end

  always_ff @(posedge clk) begin
    if (op2_r.vld) begin
      if (op2_r.to_minor) begin
        minor_r <= (op2_r.clr ? '0 : minor_r) + term_n[MW-1:0];
      end else begin
        acc_r <= acc_nxt;
        if (op2_r.store) begin
          cof_r[op2_r.cof_idx] <= acc_nxt[CW-1:0];
        end
      end
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// File: rtl/m4inv_div.sv
`default_nettype none
module m4inv_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [m4inv_pkg::CofW-1:0]    cof,
  input  wire logic [m4inv_pkg::DmagW-1:0]   dmag,
  input  wire logic                          dneg,
  input  wire logic                          sing,
  output logic                               done,
  output logic [m4inv_pkg::QuotW-1:0]        result
);

  localparam int CW = m4inv_pkg::CofW;
  localparam int NW = m4inv_pkg::NumW;
  localparam int EW = m4inv_pkg::DenW;
  localparam int QW = m4inv_pkg::QuotW;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIN  = 3'b100
  } dv_state_t;

  dv_state_t      state_r;
  dv_state_t      state_nxt;
  logic [4:0]     step_r;
  logic [NW-1:0]  rem_r;
  logic [EW-1:0]  den_r;
  logic [QW-1:0]  q_r;
  logic           qneg_r;
  logic           aneg_r;
  logic           sing_r;
  logic           mzero_r;
  logic           done_r;
  logic [QW-1:0]  result_r;

  logic [CW-1:0]  mag;
  logic           ge;
  logic [64:0]    shr;
  logic           big;
  logic           neg;
  logic [QW-1:0]  res_nxt;

  assign mag = cof[CW-1] ? (~cof + 1'b1) : cof;
  assign ge = {{(EW-NW){1'b0}}, rem_r} >= den_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (start) state_nxt = sing ? DV_FIN : DV_RUN;
      DV_RUN:  if (step_r == 5'd0) state_nxt = DV_FIN;
      DV_FIN:  state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  // final result: singular shifts the cofactor down, else uses the quotient; both saturate to 32 bits
  always_comb begin
    shr = rem_r[NW-1:64];
    if (sing_r) begin
      big = |shr[64:31];
      neg = aneg_r;
    end else begin
      big = q_r[QW-1] && !mzero_r;
      neg = qneg_r;
    end
    if (!sing_r && mzero_r) begin
      res_nxt = '0;
    end else if (big) begin
      res_nxt = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (sing_r) begin
      res_nxt = neg ? (32'd0 - {1'b0, shr[30:0]}) : {1'b0, shr[30:0]};
    end else begin
      res_nxt = neg ? (32'd0 - {1'b0, q_r[30:0]}) : {1'b0, q_r[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= (state_r == DV_FIN);
      if (state_r == DV_IDLE) begin
        step_r <= 5'd31;
      end else if (state_r == DV_RUN) begin
        step_r <= step_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && start) begin
      rem_r   <= {mag, 32'd0};
      den_r   <= {dmag, 31'd0};
      q_r     <= '0;
      aneg_r  <= cof[CW-1];
      qneg_r  <= cof[CW-1] ^ dneg;
      sing_r  <= sing;
      mzero_r <= (cof == '0);
    end else if (state_r == DV_RUN) begin
      if (ge) begin
        rem_r <= rem_r - den_r[NW-1:0];
      end
      q_r   <= {q_r[QW-2:0], ge};
      den_r <= den_r >> 1;
    end
    if (state_r == DV_FIN) begin
      result_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign result = result_r;

endmodule
`default_nettype wire

// File: rtl/matrix4x4_inverse_adjugate.sv
`default_nettype none
// channel   dir  beat payload
// in_ch     in   matrix_entry (signed Q16.16, row-major)
// out_ch    out  result_entry, determinant, singular, last_entry
// cfg_wr_*  in   singular_threshold (16 bits)
//
// sixteen input beats load the matrix, one per cycle while ready
// cofactors are formed in turn on the shared multiplier, then the determinant, then the singular check
// each result then waits on the restoring divider, which skips the division if singular
// ready is low from the sixteenth beat until the last result beat is taken
// rst_n is synchronous; the output beat is held until out_ch.ready
module matrix4x4_inverse_adjugate (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  m4inv_entry_if.sink                           in_ch,
  m4inv_result_if.source                        out_ch,
  input  wire logic                             cfg_wr_en,
  input  wire logic [m4inv_pkg::ThrW-1:0]       cfg_wr_data
);

  localparam int AW = m4inv_pkg::AccW;
  localparam int GW = m4inv_pkg::DmagW;
  localparam int CW = m4inv_pkg::CofW;
  localparam int QW = m4inv_pkg::QuotW;
  localparam int TW = m4inv_pkg::ThrW;

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_COF    = 9'b000000010,
    S_DET    = 9'b000000100,
    S_DRAIN  = 9'b000001000,
    S_ABS    = 9'b000010000,
    S_CHECK  = 9'b000100000,
    S_DSTART = 9'b001000000,
    S_DWAIT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t              state_r;
  logic [3:0]          ld_cnt_r;
  logic [3:0]          k_r;
  logic [1:0]          j_r;
  logic [2:0]          t_r;
  logic [3:0]          kout_r;
  logic [TW-1:0]       thr_r;
  logic                dneg_r;
  logic [GW-1:0]       dmag_r;
  logic                sing_r;
  logic [QW-1:0]       det_out_r;
  logic [QW-1:0]       out_entry_r;

  m4inv_pkg::mac_op_t  op;
  logic [AW-1:0]       acc;
  logic [CW-1:0]       cof_rd_data;
  logic                in_fire;
  logic                out_fire;
  logic                div_done;
  logic [QW-1:0]       div_result;
  logic [AW-1:0]       acc_abs;
  logic [GW-49:0]      det_sh;
  logic                det_big;
  logic                sing_nxt;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // micro-op issue for cofactor and determinant passes
  always_comb begin
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] ro0;
    logic [1:0] ro1;
    logic [1:0] ro2;
    logic [1:0] coj;
    logic [1:0] ca;
    logic [1:0] cb;
    r   = k_r[3:2];
    c   = k_r[1:0];
    ro0 = m4inv_pkg::skip_idx(r, 2'd0);
    ro1 = m4inv_pkg::skip_idx(r, 2'd1);
    ro2 = m4inv_pkg::skip_idx(r, 2'd2);
    coj = m4inv_pkg::skip_idx(c, j_r);
    ca  = (j_r == 2'd0) ? m4inv_pkg::skip_idx(c, 2'd1) : m4inv_pkg::skip_idx(c, 2'd0);
    cb  = (j_r == 2'd2) ? m4inv_pkg::skip_idx(c, 2'd1) : m4inv_pkg::skip_idx(c, 2'd2);
    op.vld      = 1'b0;
    op.asel     = m4inv_pkg::ASEL_ENTRY;
    op.piece    = 2'd0;
    op.neg      = 1'b0;
    op.clr      = 1'b0;
    op.to_minor = 1'b0;
    op.store    = 1'b0;
    op.cof_idx  = k_r;
    op.addr_a   = '0;
    op.addr_b   = '0;
    if (state_r == S_COF) begin
      case (t_r)
        3'd0: begin
          op.vld = 1'b1;
          op.to_minor = 1'b1;
          op.clr = 1'b1;
          op.addr_a = {ro1, ca};
          op.addr_b = {ro2, cb};
        end
        3'd1: begin
          op.vld = 1'b1;
          op.to_minor = 1'b1;
          op.neg = 1'b1;
          op.addr_a = {ro1, cb};
          op.addr_b = {ro2, ca};
        end
        3'd3, 3'd4: begin
          op.vld = 1'b1;
          op.asel = m4inv_pkg::ASEL_MINOR;
          op.piece = {1'b0, t_r == 3'd4};
          op.neg = (j_r == 2'd1) ^ r[0] ^ c[0];
          op.clr = (j_r == 2'd0) && (t_r == 3'd3);
          op.store = (j_r == 2'd2) && (t_r == 3'd4);
          op.addr_b = {ro0, coj};
        end
        default: op.vld = 1'b0;
      endcase
    end else if (state_r == S_DET) begin
      op.vld = 1'b1;
      op.asel = m4inv_pkg::ASEL_COF;
      op.piece = j_r;
      op.clr = (c == 2'd0) && (j_r == 2'd0);
      op.cof_idx = {2'b00, c};
      op.addr_b = {2'b00, c};
    end
  end

  m4inv_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (in_fire),
    .wr_addr     (ld_cnt_r),
    .wr_data     (in_ch.matrix_entry),
    .op          (op),
    .cof_rd_idx  ({kout_r[1:0], kout_r[3:2]}),
    .cof_rd_data (cof_rd_data),
    .acc         (acc)
  );

  m4inv_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_DSTART),
    .cof    (cof_rd_data),
    .dmag   (dmag_r),
    .dneg   (dneg_r),
    .sing   (sing_r),
    .done   (div_done),
    .result (div_result)
  );

  assign acc_abs  = acc[AW-1] ? (~acc + 1'b1) : acc;
  assign sing_nxt = dmag_r < GW'({thr_r, 48'd0});
  assign det_sh   = dmag_r[GW-1:48];
  assign det_big  = |det_sh[GW-49:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      ld_cnt_r <= '0;
      k_r      <= '0;
      j_r      <= '0;
      t_r      <= '0;
      kout_r   <= '0;
      thr_r    <= m4inv_pkg::ThrReset;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            ld_cnt_r <= ld_cnt_r + 4'd1;
            if (ld_cnt_r == 4'd15) begin
              state_r <= S_COF;
            end
          end
        end
        S_COF: begin
          if (t_r == 3'd4) begin
            t_r <= '0;
            if (j_r == 2'd2) begin
              j_r <= '0;
              k_r <= k_r + 4'd1;
              if (k_r == 4'd15) begin
                state_r <= S_DET;
              end
            end else begin
              j_r <= j_r + 2'd1;
            end
          end else begin
            t_r <= t_r + 3'd1;
          end
        end
        S_DET: begin
          if (j_r == 2'd2) begin
            j_r <= '0;
            if (k_r[1:0] == 2'd3) begin
              k_r <= '0;
              state_r <= S_DRAIN;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end else begin
            j_r <= j_r + 2'd1;
          end
        end
        S_DRAIN: begin
          if (t_r == 3'd1) begin
            t_r <= '0;
            state_r <= S_ABS;
          end else begin
            t_r <= t_r + 3'd1;
          end
        end
        S_ABS:    state_r <= S_CHECK;
        S_CHECK:  state_r <= S_DSTART;
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            kout_r <= kout_r + 4'd1;
            state_r <= (kout_r == 4'd15) ? S_LOAD : S_DSTART;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ABS) begin
      dneg_r <= acc[AW-1];
      dmag_r <= acc_abs[GW-1:0];
    end
    if (state_r == S_CHECK) begin
      sing_r <= sing_nxt;
      if (sing_nxt) begin
        det_out_r <= '0;
      end else if (det_big) begin
        det_out_r <= dneg_r ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        det_out_r <= dneg_r ? (32'd0 - {1'b0, det_sh[30:0]}) : {1'b0, det_sh[30:0]};
      end
    end
    if (state_r == S_DWAIT && div_done) begin
      out_entry_r <= div_result;
    end
  end

  assign in_ch.ready         = (state_r == S_LOAD);
  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.result_entry = out_entry_r;
  assign out_ch.determinant  = det_out_r;
  assign out_ch.singular     = sing_r;
  assign out_ch.last_entry   = (kout_r == 4'd15);

endmodule
`default_nettype wire
